>>> hw/rtl/bvd_pkg.sv
// shared types and constants for the bvlc header deframer
`default_nettype none
package bvd_pkg;

    localparam int unsigned HDR_LEN     = 4;
    localparam int unsigned FWD_HDR_LEN = 10;
    localparam int unsigned ADDR_LEN    = 6;
    localparam int unsigned BYTE_BITS   = 8;

    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [7:0] REG_LINK_TYPE = 8'd0;
    localparam logic [7:0] REG_FWD_CODE  = 8'd1;
    localparam logic [7:0] REG_UNI_CODE  = 8'd2;
    localparam logic [7:0] REG_BCAST     = 8'd3;

    localparam logic [7:0] RST_LINK_TYPE = 8'd129;
    localparam logic [7:0] RST_FWD_CODE  = 8'd4;
    localparam logic [7:0] RST_UNI_CODE  = 8'd10;
    localparam logic [7:0] RST_BCAST     = 8'd11;

    // result kinds
    localparam logic [1:0] KIND_ADDR    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // verdict codes
    localparam logic [2:0] V_FWD_OK    = 3'd0;
    localparam logic [2:0] V_UNI_OK    = 3'd1;
    localparam logic [2:0] V_BCAST_OK  = 3'd2;
    localparam logic [2:0] V_SHORT     = 3'd3;
    localparam logic [2:0] V_BAD_TYPE  = 3'd4;
    localparam logic [2:0] V_LEN_MISM  = 3'd5;
    localparam logic [2:0] V_FWD_SHORT = 3'd6;
    localparam logic [2:0] V_UNKNOWN   = 3'd7;

    // one queued word: an optional data item followed by an optional verdict
    typedef struct packed {
        logic       has_data;
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] pos;
        logic       has_verdict;
        logic [2:0] verdict;
    } bvd_entry_t;

    typedef struct packed {
        logic [7:0] link_type_code;
        logic [7:0] forwarded_code;
        logic [7:0] unicast_code;
        logic [7:0] broadcast_code;
    } bvd_cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/bvd_front.sv
// front end: config registers, header parsing, byte classification and verdict
`default_nettype none
module bvd_front
    import bvd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic       frame_end,
    output bvd_entry_t      entry,
    output logic            entry_push
);

    bvd_cfg_t    cfg_reg;
    logic [15:0] byte_count_reg, byte_count_next;
    logic        type_matched_reg, type_matched_next;
    logic [7:0]  function_seen_reg, function_seen_next;
    logic [15:0] declared_length_reg, declared_length_next;

    logic        overflow;
    logic [15:0] count_inc;
    logic        is_fwd, is_uni, is_bcast;
    logic [2:0]  v;
    logic [2:0]  addr_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_type_code <= RST_LINK_TYPE;
            cfg_reg.forwarded_code <= RST_FWD_CODE;
            cfg_reg.unicast_code   <= RST_UNI_CODE;
            cfg_reg.broadcast_code <= RST_BCAST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_LINK_TYPE) cfg_reg.link_type_code <= cfg_data;
            if (cfg_index == REG_FWD_CODE)  cfg_reg.forwarded_code <= cfg_data;
            if (cfg_index == REG_UNI_CODE)  cfg_reg.unicast_code   <= cfg_data;
            if (cfg_index == REG_BCAST)     cfg_reg.broadcast_code <= cfg_data;
        end
    end

    always_comb
    begin
        overflow             = (byte_count_reg == 16'hFFFF);
        count_inc            = overflow ? byte_count_reg : byte_count_reg + 16'd1;
        type_matched_next    = type_matched_reg;
        function_seen_next   = function_seen_reg;
        declared_length_next = declared_length_reg;
        if (byte_count_reg == 16'd0)
            type_matched_next = (rx_byte == cfg_reg.link_type_code);
        else if (byte_count_reg == 16'd1)
            function_seen_next = rx_byte;
        else if (byte_count_reg == 16'd2)
            declared_length_next = {rx_byte, 8'd0};
        else if (byte_count_reg == 16'd3)
            declared_length_next = {declared_length_reg[15:8], rx_byte};

        is_fwd   = (function_seen_next == cfg_reg.forwarded_code);
        is_uni   = (function_seen_next == cfg_reg.unicast_code);
        is_bcast = (function_seen_next == cfg_reg.broadcast_code);
        addr_off = byte_count_reg[2:0] - 3'(HDR_LEN);

        entry.data     = rx_byte;
        entry.has_data = 1'b0;
        entry.kind     = KIND_PAYLOAD;
        entry.pos      = 3'd0;
        if (byte_count_reg >= 16'(HDR_LEN) && type_matched_reg)
        begin
            if (is_fwd)
            begin
                entry.has_data = 1'b1;
                if (byte_count_reg < 16'(FWD_HDR_LEN))
                begin
                    entry.kind = KIND_ADDR;
                    entry.pos  = addr_off;
                end
            end
            else if (is_uni || is_bcast)
                entry.has_data = 1'b1;
        end

        // verdict in priority order, using this byte's header updates
        priority if (count_inc < 16'(HDR_LEN))
            v = V_SHORT;
        else if (!type_matched_next)
            v = V_BAD_TYPE;
        else if (overflow || count_inc != declared_length_next)
            v = V_LEN_MISM;
        else if (is_fwd)
            v = (declared_length_next < 16'(FWD_HDR_LEN)) ? V_FWD_SHORT : V_FWD_OK;
        else if (is_uni)
            v = V_UNI_OK;
        else if (is_bcast)
            v = V_BCAST_OK;
        else
            v = V_UNKNOWN;

        entry.has_verdict = frame_end;
        entry.verdict     = v;
        entry_push        = in_accept && (entry.has_data || frame_end);

        byte_count_next = count_inc;
        if (frame_end)
        begin
            byte_count_next      = 16'd0;
            type_matched_next    = 1'b0;
            function_seen_next   = 8'd0;
            declared_length_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= 16'd0;
            type_matched_reg    <= 1'b0;
            function_seen_reg   <= 8'd0;
            declared_length_reg <= 16'd0;
        end
        else if (in_accept)
        begin
            byte_count_reg      <= byte_count_next;
            type_matched_reg    <= type_matched_next;
            function_seen_reg   <= function_seen_next;
            declared_length_reg <= declared_length_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/bvd_fifo.sv
// short register queue between front and back
`default_nettype none
module bvd_fifo
    import bvd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire bvd_entry_t push_word,
    input  wire logic       pop,
    output bvd_entry_t      head,
    output logic            empty,
    output logic            full
);

    bvd_entry_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]     count_reg, count_next;
    logic                      do_push, do_pop;

    assign empty   = (count_reg == FIFO_CNT_W'(0));
    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/bvd_back.sv
// back end: expands each queued word into one or two result words
`default_nettype none
module bvd_back
    import bvd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire bvd_entry_t head,
    input  wire logic       empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      item_kind,
    output logic [7:0]      out_byte,
    output logic [2:0]      addr_position,
    output logic [2:0]      verdict,
    output logic            last_of_run
);

    // set once the data half of a two-result word has gone out
    logic phase_reg, phase_next;
    logic send_data, out_acc;

    assign out_valid = !empty;
    assign out_acc   = out_valid && !out_stall;
    assign send_data = head.has_data && !phase_reg;

    always_comb
    begin
        if (send_data)
        begin
            item_kind     = head.kind;
            out_byte      = head.data;
            addr_position = head.pos;
            verdict       = 3'd0;
            last_of_run   = !head.has_verdict;
        end
        else
        begin
            item_kind     = KIND_VERDICT;
            out_byte      = 8'd0;
            addr_position = 3'd0;
            verdict       = head.verdict;
            last_of_run   = 1'b1;
        end

        pop        = 1'b0;
        phase_next = phase_reg;
        if (out_acc)
        begin
            if (send_data && head.has_verdict)
                phase_next = 1'b1;
            else
            begin
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else
            phase_reg <= phase_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/bvlc_header_deframer_top.sv
// top level of the bvlc receive header deframer
// a byte's results are registered in the queue and offered from its head
// throughput: one byte per cycle unless in_stall; a final byte with data gives
//   two result words, absorbed by the four-word queue between front and back
// reset: asynchronous active-low rst_n clears frame state and queue and loads
//   the default link type and function codes
`default_nettype none
module bvlc_header_deframer_top
    import bvd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       frame_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      item_kind,
    output logic [7:0]      out_byte,
    output logic [2:0]      addr_position,
    output logic [2:0]      verdict,
    output logic            last_of_run
);

    bvd_entry_t entry, head;
    logic       entry_push, pop, empty, full, in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign in_accept = in_valid && !in_stall;

    bvd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .rx_byte    (rx_byte),
        .frame_end  (frame_end),
        .entry      (entry),
        .entry_push (entry_push)
    );

    bvd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (entry_push),
        .push_word (entry),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    bvd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .item_kind     (item_kind),
        .out_byte      (out_byte),
        .addr_position (addr_position),
        .verdict       (verdict),
        .last_of_run   (last_of_run)
    );

endmodule
`default_nettype wire
